// ----- rtl/fqkr_pkg.sv -----
// ----------------------------------------------------------------------------
// fqkr_pkg
// Shared types and codes for the handle queue with removal by key.
// ----------------------------------------------------------------------------
package fqkr_pkg;

	localparam logic [1:0] MODE_PUSH   = 2'd0;
	localparam logic [1:0] MODE_POP    = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STATUS_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [15:0] out_handle;
		logic [1:0]  status;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

// ----- rtl/fqkr_cell.sv -----
// ----------------------------------------------------------------------------
// fqkr_cell
// One queue slot. It either takes the value of its neighbour nearer the tail
// (a shift towards the head) or loads the tail value offered to the chain, and otherwise holds.
// ----------------------------------------------------------------------------
module fqkr_cell #(
	parameter int WIDTH = 16
) (
	input  logic                   clk,
	input  fqkr_pkg::cell_ctrl_t   ctrl,
	input  logic [WIDTH-1:0]       next_data,
	input  logic [WIDTH-1:0]       load_data,
	output logic [WIDTH-1:0]       data
);

	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

// ----- rtl/fifo_queue_with_keyed_removal_top.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_keyed_removal_top
// First-in first-out queue of process handles with push, pop and removal of
// the first entry that matches a given handle.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH slot cells with the head in cell 0. The response
// to a push or a pop is registered and appears in the cycle after the command
// is accepted; a new transaction is taken every cycle while responses are
// drained and no remove sweep runs. A remove rotates the whole row past the
// head comparator one entry per cycle, drops the first matching entry instead
// of writing it back at the tail, and leaves the remaining entries in their
// original order. A remove on an empty queue answers NOT_FOUND without a
// sweep. Only the low HANDLE_BITS bits of a handle are held.
module fifo_queue_with_keyed_removal_top #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  fqkr_pkg::cmd_t   cmd,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output fqkr_pkg::rsp_t   rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_ROTATE
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       remaining_q;
	logic                   found_q;
	logic [HANDLE_BITS-1:0] key_q;
	logic                   rsp_valid_q;
	fqkr_pkg::rsp_t         rsp_q;

	logic [HANDLE_BITS-1:0] cell_data [DEPTH];
	logic [HANDLE_BITS-1:0] cell_next [DEPTH];
	fqkr_pkg::cell_ctrl_t   cell_ctrl [DEPTH];

	logic [HANDLE_BITS+15:0] cmd_handle_ext;
	logic [HANDLE_BITS-1:0]  cmd_key;
	logic                    accept;
	logic                    is_full;
	logic                    is_empty;
	logic                    do_push;
	logic                    do_pop;
	logic                    rotating;
	logic                    head_hit;
	logic                    shift_all;
	logic                    load_en;
	logic [CNT_W-1:0]        load_idx;
	logic [HANDLE_BITS-1:0]  load_data;

	function automatic fqkr_pkg::rsp_t make_rsp(
		input logic [HANDLE_BITS-1:0] h,
		input logic [1:0]             st,
		input logic [CNT_W-1:0]       n
	);
		fqkr_pkg::rsp_t          r;
		logic [HANDLE_BITS+15:0] h_ext;
		logic [CNT_W+4:0]        n_ext;
		h_ext        = {16'b0, h};
		n_ext        = {5'b0, n};
		r.out_handle = h_ext[15:0];
		r.status     = st;
		r.occupancy  = n_ext[4:0];
		return r;
	endfunction

	assign cmd_handle_ext = {{HANDLE_BITS{1'b0}}, cmd.handle};
	assign cmd_key        = cmd_handle_ext[HANDLE_BITS-1:0];

	assign cmd_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = cmd_valid && cmd_ready;
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign do_push   = accept && (cmd.mode == fqkr_pkg::MODE_PUSH) && !is_full;
	assign do_pop    = accept && (cmd.mode == fqkr_pkg::MODE_POP) && !is_empty;
	assign rotating  = (state_q == S_ROTATE);
	assign head_hit  = rotating && !found_q && (cell_data[0] == key_q);
	assign shift_all = do_pop || rotating;
	assign load_en   = do_push || (rotating && !head_hit);
	assign load_idx  = do_push ? count_q : (count_q - CNT_W'(1));
	assign load_data = do_push ? cmd_key : cell_data[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i < DEPTH - 1) begin : g_inner
			assign cell_next[i] = cell_data[i+1];
		end else begin : g_last
			assign cell_next[i] = '0;
		end

		assign cell_ctrl[i].shift = shift_all;
		assign cell_ctrl[i].load  = load_en && (load_idx == CNT_W'(i));

		fqkr_cell #(
			.WIDTH(HANDLE_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.next_data(cell_next[i]),
			.load_data(load_data),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			remaining_q <= '0;
			found_q     <= 1'b0;
			key_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !accept) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.mode)
							fqkr_pkg::MODE_PUSH: begin
								rsp_valid_q <= 1'b1;
								if (is_full) begin
									rsp_q <= make_rsp('0, fqkr_pkg::STATUS_FULL, count_q);
								end else begin
									count_q <= count_q + CNT_W'(1);
									rsp_q   <= make_rsp('0, fqkr_pkg::STATUS_OK,
										count_q + CNT_W'(1));
								end
							end
							fqkr_pkg::MODE_POP: begin
								rsp_valid_q <= 1'b1;
								if (is_empty) begin
									rsp_q <= make_rsp('0, fqkr_pkg::STATUS_EMPTY, count_q);
								end else begin
									count_q <= count_q - CNT_W'(1);
									rsp_q   <= make_rsp(cell_data[0], fqkr_pkg::STATUS_OK,
										count_q - CNT_W'(1));
								end
							end
							fqkr_pkg::MODE_REMOVE: begin
								if (is_empty) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= make_rsp('0, fqkr_pkg::STATUS_NOT_FOUND, count_q);
								end else begin
									rsp_valid_q <= 1'b0;
									state_q     <= S_ROTATE;
									key_q       <= cmd_key;
									remaining_q <= count_q;
									found_q     <= 1'b0;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
								rsp_q <= make_rsp('0, fqkr_pkg::STATUS_OK, count_q);
							end
						endcase
					end
				end
				S_ROTATE: begin
					remaining_q <= remaining_q - CNT_W'(1);
					if (head_hit) begin
						found_q <= 1'b1;
						count_q <= count_q - CNT_W'(1);
					end
					if (remaining_q == CNT_W'(1)) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
						rsp_q       <= make_rsp('0,
							(found_q || head_hit) ? fqkr_pkg::STATUS_OK
								: fqkr_pkg::STATUS_NOT_FOUND,
							head_hit ? (count_q - CNT_W'(1)) : count_q);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Entry count exceeds the queue depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rotating |-> !rsp_valid_q && !cmd_ready)
		else $error("Response or new transaction during a remove sweep.");

	assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("Accepted push did not grow the queue by one.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rotating && remaining_q == CNT_W'(1)) |=> state_q == S_IDLE && rsp_valid_q)
		else $error("Remove sweep ended without a response.");

endmodule

// ----- test/fifo_queue_with_keyed_removal_checker.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_keyed_removal_checker
// Watches both channels of the handle queue, predicts every response from its
// own copy of the queue contents, and compares each response field by field.
// ----------------------------------------------------------------------------
module fifo_queue_with_keyed_removal_checker #(
	parameter int DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  logic            cmd_ready,
	input  fqkr_pkg::cmd_t  cmd,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  fqkr_pkg::rsp_t  rsp,
	output int              mismatches,
	output int              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0]    held_handles [$];
	fqkr_pkg::rsp_t expected_rsps [$];
	int             error_total = 0;

	function automatic fqkr_pkg::rsp_t apply_queue_op(input fqkr_pkg::cmd_t c);
		fqkr_pkg::rsp_t r;
		int             hit;
		r   = '0;
		hit = -1;
		case (c.mode)
			fqkr_pkg::MODE_PUSH: begin
				if (held_handles.size() >= DEPTH) begin
					r.status = fqkr_pkg::STATUS_FULL;
				end else begin
					held_handles.push_back(c.handle);
				end
			end
			fqkr_pkg::MODE_POP: begin
				if (held_handles.size() == 0) begin
					r.status = fqkr_pkg::STATUS_EMPTY;
				end else begin
					r.out_handle = held_handles.pop_front();
				end
			end
			fqkr_pkg::MODE_REMOVE: begin
				for (int i = 0; i < held_handles.size() && hit < 0; i++) begin
					if (held_handles[i] == c.handle) begin
						hit = i;
					end
				end
				if (hit < 0) begin
					r.status = fqkr_pkg::STATUS_NOT_FOUND;
				end else begin
					held_handles.delete(hit);
				end
			end
			default: begin
			end
		endcase
		r.occupancy = 5'(held_handles.size());
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t checker: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		fqkr_pkg::rsp_t want;
		if (!arst_n) begin
			held_handles.delete();
			expected_rsps.delete();
			error_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("response with no transaction outstanding",
						rsp.out_handle, 0);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.out_handle !== want.out_handle) begin
						report_mismatch("out_handle", rsp.out_handle, want.out_handle);
					end
					if (rsp.status !== want.status) begin
						report_mismatch("status", rsp.status, want.status);
					end
					if (rsp.occupancy !== want.occupancy) begin
						report_mismatch("occupancy", rsp.occupancy, want.occupancy);
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				expected_rsps.push_back(apply_queue_op(cmd));
			end
			mismatches  <= error_total;
			outstanding <= expected_rsps.size();
		end
	end

endmodule

// ----- test/tb_fifo_queue_with_keyed_removal_top.sv -----
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_keyed_removal_top
// Drives directed and random push, pop and remove transactions into the handle
// queue with random idling on both channels and gives the final verdict.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_keyed_removal_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS    = 1500;
	localparam int QUIET_TAIL     = 200;
	localparam int HOLDOFF_AT     = 400;
	localparam int HOLDOFF_CYCLES = 150;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cmd_valid = 1'b0;
	fqkr_pkg::cmd_t cmd       = '0;
	logic           rsp_ready = 1'b0;
	logic           cmd_ready;
	logic           rsp_valid;
	fqkr_pkg::rsp_t rsp;

	int mismatches;
	int outstanding;
	int items_sent  = 0;
	int idle_cycles = 0;
	bit quiet       = 1'b0;

	always #5 clk = ~clk;

	fifo_queue_with_keyed_removal_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	fifo_queue_with_keyed_removal_checker queue_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	task automatic send_cmd(input logic [1:0] m, input logic [15:0] h);
		cmd_valid <= 1'b1;
		cmd       <= '{mode: m, handle: h};
		do @(posedge clk); while (!cmd_ready);
		items_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		logic [15:0] pool [8];
		logic [1:0]  m;
		logic [15:0] h;
		int          push_weight;
		int          pick;
		pool[0] = 16'h0000;
		pool[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++) begin
			pool[i] = 16'($urandom);
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(fqkr_pkg::MODE_POP, 16'hFFFF);
		send_cmd(fqkr_pkg::MODE_REMOVE, 16'h0000);
		send_cmd(fqkr_pkg::MODE_PUSH, 16'h0000);
		send_cmd(fqkr_pkg::MODE_REMOVE, 16'h0000);
		send_cmd(fqkr_pkg::MODE_PUSH, 16'hFFFF);
		send_cmd(fqkr_pkg::MODE_PUSH, 16'h1234);
		send_cmd(fqkr_pkg::MODE_PUSH, 16'hFFFF);
		send_cmd(fqkr_pkg::MODE_PUSH, 16'h8001);
		send_cmd(fqkr_pkg::MODE_REMOVE, 16'hFFFF);
		send_cmd(fqkr_pkg::MODE_REMOVE, 16'h7777);
		send_cmd(fqkr_pkg::MODE_POP, 16'h0000);
		for (int i = 0; i < 14; i++) begin
			send_cmd(fqkr_pkg::MODE_PUSH, 16'(16'h0100 + i));
		end
		send_cmd(fqkr_pkg::MODE_PUSH, 16'hBEEF);
		send_cmd(fqkr_pkg::MODE_REMOVE, 16'h010D);
		send_cmd(fqkr_pkg::MODE_REMOVE, 16'h8001);

		// Hold back until every response to the directed part has been taken.
		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);

		push_weight = 50;
		for (int n = 0; n < TOTAL_ITEMS; n++) begin
			if (n % 100 == 0) begin
				case ((n / 100) % 3)
					0:       push_weight = 75;
					1:       push_weight = 25;
					default: push_weight = 50;
				endcase
			end
			quiet = (n >= TOTAL_ITEMS - QUIET_TAIL);
			pick  = $urandom_range(0, 99);
			if (pick < push_weight) begin
				m = fqkr_pkg::MODE_PUSH;
			end else if (pick < push_weight + (100 - push_weight) / 2) begin
				m = fqkr_pkg::MODE_POP;
			end else begin
				m = fqkr_pkg::MODE_REMOVE;
			end
			if ($urandom_range(0, 9) < 7) begin
				h = pool[$urandom_range(0, 7)];
			end else begin
				h = 16'($urandom);
			end
			send_cmd(m, h);
		end

		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("fifo_queue_with_keyed_removal_top verification clean");
		end else begin
			$display("fifo_queue_with_keyed_removal_top verification failed");
		end
		$finish;
	end

	initial begin : drain_side
		bit held_off;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && items_sent >= HOLDOFF_AT) begin
				held_off = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fifo_queue_with_keyed_removal_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ----- files.f -----
rtl/fqkr_pkg.sv
rtl/fqkr_cell.sv
rtl/fifo_queue_with_keyed_removal_top.sv
test/fifo_queue_with_keyed_removal_checker.sv
test/tb_fifo_queue_with_keyed_removal_top.sv
